### sv/crp_pkg.sv
// package for the control-flow graph reverse-postorder renumbering block
// shared widths, command/status structs and the controller state encoding
// no dependencies
package crp_pkg;

    localparam int MaxBlocks = 64;
    localparam int IdxW      = $clog2(MaxBlocks);
    localparam int CntW      = IdxW + 1;
    localparam int SuccW     = 7;
    localparam int StkW      = IdxW + 2;

    localparam logic [SuccW-1:0] SuccNone = {SuccW{1'b1}};

    // stack entry phases
    localparam logic [1:0] PhSecond = 2'd0;
    localparam logic [1:0] PhFirst  = 2'd1;
    localparam logic [1:0] PhDone   = 2'd2;

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_CLEAR  = 10'b0000000010,
        ST_WROOT  = 10'b0000000100,
        ST_WTOP   = 10'b0000001000,
        ST_WSTEP  = 10'b0000010000,
        ST_EINV   = 10'b0000100000,
        ST_ESUCC  = 10'b0001000000,
        ST_ERD    = 10'b0010000000,
        ST_EOUT   = 10'b0100000000,
        ST_ERST   = 10'b1000000000
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // store the incoming successor pair
        logic clear_vis;   // clear visited bits
        logic push_root;   // start walk at block 0
        logic read_top;    // fetch successor pair of stack top
        logic step;        // one walk step on the fetched pair
        logic emit_adv;    // load output slot and advance emit position
        logic reset_graph; // clear graph state after emission
    } crp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic stack_empty;
        logic emit_last;
        logic full;
    } crp_stat_t;

    // usable successor: nonnegative and below loaded count
    function automatic logic succ_ok(input logic [SuccW-1:0] raw,
                                     input logic [CntW-1:0] cnt);
        succ_ok = !raw[SuccW-1] && ({1'b0, raw[IdxW-1:0]} < cnt);
    endfunction

endpackage

### sv/crp_ram.sv
// generic single-port-write, one-read memory with registered read data
// no dependencies
module crp_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/crp_ctrl.sv
// controller state machine for the reverse-postorder block
// depends on crp_pkg
module crp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_tlast,
    output crp_pkg::crp_cmd_t  cmd,
    input  crp_pkg::crp_stat_t stat
);
    import crp_pkg::*;

    state_t state_reg, state_next;
    logic   ovld_reg, ovld_next;
    logic   olast_reg, olast_next;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = ovld_reg;
    assign m_tlast  = olast_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ovld_next  = ovld_reg;
        olast_next = olast_reg;
        cmd        = '0;
        if (ovld_reg && m_tready) begin
            ovld_next = 1'b0;
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load = !stat.full;
                    if (s_tlast) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear_vis = 1'b1;
                state_next    = ST_WROOT;
            end
            ST_WROOT: begin
                cmd.push_root = 1'b1;
                state_next    = ST_WTOP;
            end
            ST_WTOP: begin
                if (stat.stack_empty) begin
                    state_next = ST_EINV;
                end else begin
                    cmd.read_top = 1'b1;
                    state_next   = ST_WSTEP;
                end
            end
            ST_WSTEP: begin
                cmd.step   = 1'b1;
                state_next = ST_WTOP;
            end
            // wait for inverse map, then successor table reads
            ST_EINV: begin
                state_next = ST_ESUCC;
            end
            ST_ESUCC: begin
                state_next = ST_ERD;
            end
            ST_ERD: begin
                if (!ovld_next) begin
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT: begin
                ovld_next  = 1'b1;
                olast_next = stat.emit_last;
                cmd.emit_adv = 1'b1;
                state_next = stat.emit_last ? ST_ERST : ST_EINV;
            end
            ST_ERST: begin
                cmd.reset_graph = 1'b1;
                state_next      = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ovld_reg  <= 1'b0;
            olast_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
            olast_reg <= olast_next;
        end
    end

`ifndef ASSERT_OFF
    // input only taken while loading
    a_load_only: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_LOAD) else $error("ready outside load");
    // output held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    // emission step only when output slot is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EOUT |-> !ovld_reg) else $error("result overwritten");
`endif
endmodule

### sv/crp_dpath.sv
// datapath: successor table, visited flags, walk stack, order numbers and inverse map
// depends on crp_pkg and crp_ram
module crp_dpath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [crp_pkg::SuccW-1:0] succ_first,
    input  logic [crp_pkg::SuccW-1:0] succ_second,
    input  crp_pkg::crp_cmd_t         cmd,
    output crp_pkg::crp_stat_t        stat,
    output logic [crp_pkg::IdxW-1:0]  old_index,
    output logic [crp_pkg::SuccW-1:0] new_succ_first,
    output logic [crp_pkg::SuccW-1:0] new_succ_second,
    output logic [crp_pkg::CntW-1:0]  reachable_count
);
    import crp_pkg::*;

    logic [CntW-1:0]      loaded_reg, loaded_next;
    logic [CntW-1:0]      num_reg, num_next;
    logic [CntW-1:0]      depth_reg, depth_next;
    logic [CntW-1:0]      pos_reg, pos_next;
    logic [MaxBlocks-1:0] vis_reg, vis_next;
    logic [StkW-1:0]      top_reg, top_next;
    logic [IdxW-1:0]      oidx_reg;
    logic [SuccW-1:0]     nf_reg, ns_reg;
    logic [CntW-1:0]      rc_reg;

    logic [2*SuccW-1:0] rd_data;
    logic [IdxW-1:0]    rd_addr;
    logic [1:0]         top_ph;
    logic [IdxW-1:0]    top_blk;
    logic [CntW-1:0]    reach;
    logic [SuccW-1:0]   push_raw;
    logic               push_ok;
    logic               pop;
    logic [IdxW-1:0]    num_m1;
    logic               stk_we;
    logic [IdxW-1:0]    stk_waddr;
    logic [IdxW-1:0]    stk_raddr;
    logic [StkW-1:0]    stk_rdata;
    logic [IdxW-1:0]    ord_first;
    logic [IdxW-1:0]    ord_second;
    logic [IdxW-1:0]    inv_raddr;
    logic [IdxW-1:0]    inv_rdata;

    // stack top lives in a register, entries below it in memory
    assign top_ph    = top_reg[IdxW+1:IdxW];
    assign top_blk   = top_reg[IdxW-1:0];
    assign reach     = loaded_reg - num_reg;
    assign pop       = cmd.step && (top_ph == PhDone);
    assign num_m1    = IdxW'(num_reg - 1'b1);
    assign inv_raddr = IdxW'(num_reg + pos_reg);
    assign rd_addr   = cmd.read_top ? top_blk : inv_rdata;
    assign stk_we    = cmd.step && (top_ph != PhDone) && push_ok;
    assign stk_waddr = depth_reg[IdxW-1:0] - 1'b1;
    assign stk_raddr = depth_reg[IdxW-1:0] - 2'd2;

    // successor table, second successor in the upper half
    crp_ram #(.Width(2*SuccW), .Depth(MaxBlocks)) u_succ (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (loaded_reg[IdxW-1:0]),
        .wdata ({succ_second, succ_first}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // walk stack below the top entry, read port parked on the entry under the top
    crp_ram #(.Width(StkW), .Depth(MaxBlocks)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata ({top_ph + 2'd1, top_blk}),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // order numbers, one copy per successor field
    crp_ram #(.Width(IdxW), .Depth(MaxBlocks)) u_ord_first (
        .aclk  (aclk),
        .we    (pop),
        .waddr (top_blk),
        .wdata (num_m1),
        .raddr (rd_data[IdxW-1:0]),
        .rdata (ord_first)
    );

    crp_ram #(.Width(IdxW), .Depth(MaxBlocks)) u_ord_second (
        .aclk  (aclk),
        .we    (pop),
        .waddr (top_blk),
        .wdata (num_m1),
        .raddr (rd_data[SuccW+IdxW-1:SuccW]),
        .rdata (ord_second)
    );

    // inverse map indexed by absolute order number
    crp_ram #(.Width(IdxW), .Depth(MaxBlocks)) u_inv (
        .aclk  (aclk),
        .we    (pop),
        .waddr (num_m1),
        .wdata (top_blk),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    assign push_raw = (top_ph == PhSecond) ? rd_data[2*SuccW-1:SuccW]
                                           : rd_data[SuccW-1:0];
    assign push_ok  = succ_ok(push_raw, loaded_reg) && !vis_reg[push_raw[IdxW-1:0]]
                      && (depth_reg < CntW'(MaxBlocks));

    assign stat.stack_empty = (depth_reg == '0);
    assign stat.emit_last   = (pos_reg + 1'b1 == reach);
    assign stat.full        = (loaded_reg == CntW'(MaxBlocks));

    // renumber one successor through the order numbers
    function automatic logic [SuccW-1:0] renum(input logic [SuccW-1:0] raw,
                                               input logic [CntW-1:0] cnt,
                                               input logic [MaxBlocks-1:0] vis,
                                               input logic [IdxW-1:0] ordv,
                                               input logic [CntW-1:0] base);
        if (succ_ok(raw, cnt) && vis[raw[IdxW-1:0]]) begin
            renum = SuccW'({1'b0, ordv} - base);
        end else begin
            renum = SuccNone;
        end
    endfunction

    // control counters, flags and stack top
    always_comb begin
        loaded_next = loaded_reg;
        num_next    = num_reg;
        depth_next  = depth_reg;
        vis_next    = vis_reg;
        pos_next    = pos_reg;
        top_next    = top_reg;
        if (cmd.load) begin
            loaded_next = loaded_reg + 1'b1;
        end
        if (cmd.clear_vis) begin
            vis_next = '0;
        end
        if (cmd.push_root) begin
            vis_next[0] = 1'b1;
            depth_next  = CntW'(1);
            num_next    = loaded_reg;
            top_next    = {PhSecond, {IdxW{1'b0}}};
        end
        if (cmd.step) begin
            if (top_ph == PhDone) begin
                depth_next = depth_reg - 1'b1;
                num_next   = num_reg - 1'b1;
                top_next   = stk_rdata;
            end else if (push_ok) begin
                vis_next[push_raw[IdxW-1:0]] = 1'b1;
                depth_next = depth_reg + 1'b1;
                top_next   = {PhSecond, push_raw[IdxW-1:0]};
            end else begin
                top_next = {top_ph + 2'd1, top_blk};
            end
        end
        if (cmd.emit_adv) begin
            pos_next = pos_reg + 1'b1;
        end
        if (cmd.reset_graph) begin
            loaded_next = '0;
            num_next    = '0;
            depth_next  = '0;
            vis_next    = '0;
            pos_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
            num_reg    <= '0;
            depth_reg  <= '0;
            vis_reg    <= '0;
            pos_reg    <= '0;
            top_reg    <= '0;
        end else begin
            loaded_reg <= loaded_next;
            num_reg    <= num_next;
            depth_reg  <= depth_next;
            vis_reg    <= vis_next;
            pos_reg    <= pos_next;
            top_reg    <= top_next;
        end
    end

    // output payload, taken when the slot is loaded
    always_ff @(posedge aclk) begin
        if (cmd.emit_adv) begin
            oidx_reg <= inv_rdata;
            nf_reg   <= renum(rd_data[SuccW-1:0], loaded_reg, vis_reg,
                              ord_first, num_reg);
            ns_reg   <= renum(rd_data[2*SuccW-1:SuccW], loaded_reg, vis_reg,
                              ord_second, num_reg);
            rc_reg   <= reach;
        end
    end

    assign old_index       = oidx_reg;
    assign new_succ_first  = nf_reg;
    assign new_succ_second = ns_reg;
    assign reachable_count = rc_reg;

`ifndef ASSERT_OFF
    // stack never overflows
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CntW'(MaxBlocks)) else $error("stack overflow");
    // numbering never passes below zero
    a_num: assert property (@(posedge aclk) disable iff (!aresetn)
        num_reg <= loaded_reg) else $error("numbering underflow");
    // a pop always frees one entry
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> depth_reg == $past(depth_reg) - 1'b1)
        else $error("bad pop");
`endif
endmodule

### sv/cfg_reverse_postorder.sv
// top level of the control-flow graph reverse-postorder renumbering block
// depends on crp_pkg, crp_ctrl, crp_dpath
//
// channel   dir  tdata (low bit up)                                  tlast
// s_        in   succ_first[6:0] succ_second[13:7] pad               is_last
// m_        out  old_index[5:0] new_succ_first[12:6]
//                new_succ_second[19:13] reachable_count[26:20] pad   last_out
//
// loading stores each offered block, up to the table depth, in the successor table; on the
// last block the visited flags are cleared and the root pushed, then the walk fetches and
// steps the stack top (three steps per reachable block); emission passes each result through
// the chain of registered reads (inverse map, successor table, order numbers). reset is
// synchronous, active low; output stalls hold emission, input is refused until done.
module cfg_reverse_postorder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // succ_first, succ_second
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // old_index, new_succ_first, new_succ_second, reachable_count
    output logic        m_tlast    // last_out
);
    import crp_pkg::*;

    crp_cmd_t         cmd;
    crp_stat_t        stat;
    logic [IdxW-1:0]  old_index;
    logic [SuccW-1:0] nsf, nss;
    logic [CntW-1:0]  rcount;

    crp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    crp_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .succ_first      (s_tdata[6:0]),
        .succ_second     (s_tdata[13:7]),
        .cmd             (cmd),
        .stat            (stat),
        .old_index       (old_index),
        .new_succ_first  (nsf),
        .new_succ_second (nss),
        .reachable_count (rcount)
    );

    // pack result fields
    assign m_tdata = {5'd0, rcount, nss, nsf, old_index};
endmodule

### tb/crp_checker.sv
// result checker for the reverse-postorder renumbering block
// watches both channels, predicts each emitted run and compares field by field
// depends on crp_pkg
module crp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import crp_pkg::*;

    typedef struct packed {
        logic [IdxW-1:0]  old_index;
        logic [SuccW-1:0] nsucc_first;
        logic [SuccW-1:0] nsucc_second;
        logic [CntW-1:0]  reach_count;
        logic             last_out;
    } block_result_t;

    // graph being loaded
    logic [SuccW-1:0] graph_first [MaxBlocks];
    logic [SuccW-1:0] graph_second[MaxBlocks];
    int               graph_size;
    block_result_t    expected_blocks[$];

    task automatic report(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic bit usable(input logic [SuccW-1:0] raw, output int idx);
        idx = raw[IdxW-1:0];
        return !raw[SuccW-1] && idx < graph_size;
    endfunction

    // depth-first walk, second successor first, then emit in reverse postorder
    task automatic renumber_graph();
        int  post[MaxBlocks];
        bit  seen[MaxBlocks];
        int  stk[$];
        int  phase[MaxBlocks];
        int  by_pos[MaxBlocks];
        int  next_num, reach, b, s, ns;
        block_result_t r;
        for (int i = 0; i < MaxBlocks; i++) begin
            seen[i] = 0;
            phase[i] = 0;
        end
        next_num = graph_size;
        seen[0] = 1;
        stk.push_back(0);
        while (stk.size() > 0) begin
            b = stk[$];
            if (phase[b] == 0) begin
                phase[b] = 1;
                if (usable(graph_second[b], s) && !seen[s]) begin
                    seen[s] = 1;
                    stk.push_back(s);
                end
            end else if (phase[b] == 1) begin
                phase[b] = 2;
                if (usable(graph_first[b], s) && !seen[s]) begin
                    seen[s] = 1;
                    stk.push_back(s);
                end
            end else begin
                void'(stk.pop_back());
                next_num--;
                post[b] = next_num;
            end
        end
        reach = graph_size - next_num;
        for (int i = 0; i < graph_size; i++)
            if (seen[i]) by_pos[post[i] - next_num] = i;
        for (int p = 0; p < reach; p++) begin
            b = by_pos[p];
            r.old_index = b[IdxW-1:0];
            if (usable(graph_first[b], s) && seen[s]) begin
                ns = post[s] - next_num;
                r.nsucc_first = ns[SuccW-1:0];
            end else r.nsucc_first = SuccNone;
            if (usable(graph_second[b], s) && seen[s]) begin
                ns = post[s] - next_num;
                r.nsucc_second = ns[SuccW-1:0];
            end else r.nsucc_second = SuccNone;
            r.reach_count = reach[CntW-1:0];
            r.last_out = (p + 1 == reach);
            expected_blocks.push_back(r);
        end
        graph_size = 0;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        graph_size = 0;
    end

    // requests in, results out
    always @(posedge aclk) begin
        block_result_t e;
        if (aresetn && s_tvalid && s_tready) begin
            if (graph_size < MaxBlocks) begin
                graph_first[graph_size]  = s_tdata[6:0];
                graph_second[graph_size] = s_tdata[13:7];
                graph_size++;
            end
            if (s_tlast) renumber_graph();
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_blocks.size() == 0) begin
                report($sformatf("unexpected result %h", m_tdata));
            end else begin
                e = expected_blocks.pop_front();
                if (m_tdata[5:0] !== e.old_index)
                    report($sformatf("old_index %0d, want %0d", m_tdata[5:0], e.old_index));
                if (m_tdata[12:6] !== e.nsucc_first)
                    report($sformatf("new_succ_first %h, want %h",
                                     m_tdata[12:6], e.nsucc_first));
                if (m_tdata[19:13] !== e.nsucc_second)
                    report($sformatf("new_succ_second %h, want %h",
                                     m_tdata[19:13], e.nsucc_second));
                if (m_tdata[26:20] !== e.reach_count)
                    report($sformatf("reachable_count %0d, want %0d",
                                     m_tdata[26:20], e.reach_count));
                if (m_tlast !== e.last_out)
                    report($sformatf("last_out %b, want %b", m_tlast, e.last_out));
            end
        end
        pending = expected_blocks.size();
    end

endmodule

### tb/testbench.sv
// stimulus and verdict for the reverse-postorder renumbering block
// depends on crp_pkg, cfg_reverse_postorder and crp_checker
module testbench;
    import crp_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          hold_off = 0;
    bit          sending_done = 0;

    always #6 aclk = ~aclk;

    cfg_reverse_postorder uut (.*);

    crp_checker checker_i (.*);

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // receiver: random stalls, long hold-off stretches while one graph is sent
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (600) @(posedge aclk);
            end
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = gap_len();
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
        end
    end

    // one request, with optional gap before it
    task automatic send_block(input logic [6:0] f, input logic [6:0] s, input bit last,
                              input bit gaps);
        int n;
        if (gaps && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 0;
            n = gap_len();
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {2'b00, s, f};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // random successor, mostly in range, sometimes none or beyond count
    function automatic logic [6:0] rand_succ(input int n);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 7'h7f;
        if (k == 1) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, n - 1));
    endfunction

    task automatic send_graph(input int n, input bit gaps);
        for (int i = 0; i < n; i++)
            send_block(rand_succ(n), rand_succ(n), i == n - 1, gaps);
    endtask

    initial begin
        int sent;
        int n;
        bit pressed;
        pressed = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // single block, self loop, none
        send_block(7'h7f, 7'h7f, 1, 0);
        send_block(7'd0, 7'h40, 1, 0);
        // chain with back edge and out of range successors
        send_block(7'd1, 7'd2, 0, 0);
        send_block(7'd2, 7'd63, 0, 0);
        send_block(7'd0, 7'h3f, 1, 0);
        // unreachable block and diamond
        send_block(7'd2, 7'd1, 0, 0);
        send_block(7'd3, 7'h7f, 0, 0);
        send_block(7'd3, 7'd3, 0, 0);
        send_block(7'h7f, 7'h7f, 0, 0);
        send_block(7'd0, 7'd1, 1, 0);
        // long chain of 70 blocks, tail beyond the table is ignored
        for (int i = 0; i < 70; i++)
            send_block(7'(i + 1 < 64 ? i + 1 : 7'h55), 7'h2a, i == 69, 0);
        sent = 80;
        // random graphs, receiver holds off during one of them
        while (sent < 450) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
            if (sent > 200 && !pressed) begin
                hold_off = 1;
                pressed = 1;
            end else hold_off = 0;
            send_graph(n, $urandom_range(0, 3) != 0);
            sent += n;
        end
        hold_off = 0;
        s_tvalid <= 0;
        s_tlast  <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
